/* design/reab_pkg.sv */
// ----------------------------------------------------------------------------
// reab_pkg
// shared opcodes, condition codes, stage types and helpers for the execute
// stage of the 16-bit risc pipeline
// ----------------------------------------------------------------------------
package reab_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned OP_W    = 6;
  localparam int unsigned IMM_W   = 8;
  localparam int unsigned CC_W    = 4;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned SHAMT_W = 4;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 64;

  // flag bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_N = 2;
  localparam int unsigned FL_F = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD0   = 6'd0;
  localparam logic [OP_W-1:0] OP_ADD1   = 6'd1;
  localparam logic [OP_W-1:0] OP_ADDU0  = 6'd2;
  localparam logic [OP_W-1:0] OP_ADDU1  = 6'd3;
  localparam logic [OP_W-1:0] OP_ADD4   = 6'd4;
  localparam logic [OP_W-1:0] OP_ADD9   = 6'd9;
  localparam logic [OP_W-1:0] OP_MUL0   = 6'd10;
  localparam logic [OP_W-1:0] OP_MUL1   = 6'd11;
  localparam logic [OP_W-1:0] OP_CMP0   = 6'd12;
  localparam logic [OP_W-1:0] OP_CMP1   = 6'd13;
  localparam logic [OP_W-1:0] OP_AND0   = 6'd14;
  localparam logic [OP_W-1:0] OP_AND1   = 6'd15;
  localparam logic [OP_W-1:0] OP_OR     = 6'd16;
  localparam logic [OP_W-1:0] OP_ORI    = 6'd17;
  localparam logic [OP_W-1:0] OP_XOR    = 6'd18;
  localparam logic [OP_W-1:0] OP_XORI   = 6'd19;
  localparam logic [OP_W-1:0] OP_MOV    = 6'd20;
  localparam logic [OP_W-1:0] OP_MOVI   = 6'd21;
  localparam logic [OP_W-1:0] OP_LSH    = 6'd22;
  localparam logic [OP_W-1:0] OP_LSHI   = 6'd23;
  localparam logic [OP_W-1:0] OP_ASH    = 6'd24;
  localparam logic [OP_W-1:0] OP_ASHI   = 6'd25;
  localparam logic [OP_W-1:0] OP_LUI    = 6'd26;
  localparam logic [OP_W-1:0] OP_LOAD   = 6'd27;
  localparam logic [OP_W-1:0] OP_STORE  = 6'd28;
  localparam logic [OP_W-1:0] OP_BRANCH = 6'd29;
  localparam logic [OP_W-1:0] OP_JUMP   = 6'd30;
  localparam logic [OP_W-1:0] OP_JAL    = 6'd31;
  localparam logic [OP_W-1:0] OP_NOP    = 6'd32;

  // condition codes
  localparam logic [CC_W-1:0] CC_EQ = 4'd0;
  localparam logic [CC_W-1:0] CC_NE = 4'd1;
  localparam logic [CC_W-1:0] CC_CS = 4'd2;
  localparam logic [CC_W-1:0] CC_CC = 4'd3;
  localparam logic [CC_W-1:0] CC_N  = 4'd6;
  localparam logic [CC_W-1:0] CC_NN = 4'd7;
  localparam logic [CC_W-1:0] CC_FS = 4'd8;
  localparam logic [CC_W-1:0] CC_FC = 4'd9;
  localparam logic [CC_W-1:0] CC_LE = 4'd11;
  localparam logic [CC_W-1:0] CC_GT = 4'd12;
  localparam logic [CC_W-1:0] CC_AL = 4'd14;

  localparam logic [DATA_W-1:0] LOW_BYTE_MASK = 16'h00FF;

  // shifter control
  typedef struct packed {
    logic imm_mode;
    logic rsh;
    logic arith;
  } shift_ctl_t;

  // operand stage
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] op1;
    logic [DATA_W-1:0] op2;
    logic [DATA_W-1:0] pc;
    logic              sub;
    logic              cin;
    logic              taken;
    logic              rsh;
  } s1_t;

  // compute stage
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] sum;
    logic              carry;
    logic              ovf;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] mov_res;
    logic [DATA_W-1:0] shift_res;
    logic [DATA_W-1:0] misc_res;
    logic [DATA_W-1:0] pc_tgt;
    logic              pc_wr;
    logic [DATA_W-1:0] op2;
  } s2_t;

  function automatic logic cond_taken(input logic [CC_W-1:0] cc,
                                      input logic [FLAG_W-1:0] fl);
    logic c, z, n, f, t;
    c = fl[FL_C];
    z = fl[FL_Z];
    n = fl[FL_N];
    f = fl[FL_F];
    case (cc)
      CC_EQ: t = z;
      CC_NE: t = !z;
      CC_CS: t = c;
      CC_CC: t = !c;
      CC_N:  t = n;
      CC_NN: t = !n;
      CC_FS: t = f;
      CC_FC: t = !f;
      CC_LE: t = z || n;
      CC_GT: t = !n && !z;
      CC_AL: t = 1'b1;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

endpackage

/* design/risc_execute_alu_branch.sv */
// ----------------------------------------------------------------------------
// risc_execute_alu_branch
// execute stage of a 16-bit risc pipeline: alu, flag update, branch resolve
// ----------------------------------------------------------------------------
//  channel  | ports                         | tdata fields (lsb first)
//  input    | in_tvalid in_tready in_tdata  | op, immediate, source_value,
//           |                               | dest_value, pc_value, cond_code,
//           |                               | flags_in, use_immediate, subtract,
//           |                               | move_op, use_carry_in,
//           |                               | shift_right_imm
//  result   | out_tvalid out_tready out_tdata | alu_result, flags_out,
//           |                               | flags_write, pc_next, pc_write,
//           |                               | store_data
//
//  one instruction per cycle while the result channel is not stalled
//  three register stages: operand prep, compute units (adder, 16x16
//  multiplier, shifter), result select with flags into the output register
//  each stage holds while the one after it is full and stalled; bubbles close
//  synchronous active-low reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module risc_execute_alu_branch
  import reab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // op[5:0] immediate[13:6] source_value[29:14] dest_value[45:30]
  // pc_value[61:46] cond_code[65:62] flags_in[69:66] use_immediate[70]
  // subtract[71] move_op[72] use_carry_in[73] shift_right_imm[74] zero[79:75]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // alu_result[15:0] flags_out[19:16] flags_write[23:20] pc_next[39:24]
  // pc_write[40] store_data[56:41] zero[63:57]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [OP_W-1:0]   in_op;
  logic [IMM_W-1:0]  in_imm;
  logic [DATA_W-1:0] in_src;
  logic [DATA_W-1:0] in_dst;
  logic [DATA_W-1:0] in_pc;
  logic [CC_W-1:0]   in_cc;
  logic [FLAG_W-1:0] in_flags;
  logic              in_use_imm;
  logic              in_sub;
  logic              in_move;
  logic              in_use_cin;
  logic              in_rsh;

  assign in_op      = in_tdata[5:0];
  assign in_imm     = in_tdata[13:6];
  assign in_src     = in_tdata[29:14];
  assign in_dst     = in_tdata[45:30];
  assign in_pc      = in_tdata[61:46];
  assign in_cc      = in_tdata[65:62];
  assign in_flags   = in_tdata[69:66];
  assign in_use_imm = in_tdata[70];
  assign in_sub     = in_tdata[71];
  assign in_move    = in_tdata[72];
  assign in_use_cin = in_tdata[73];
  assign in_rsh     = in_tdata[74];

  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;

  logic [DATA_W-1:0] res_r, res_nxt;
  logic [FLAG_W-1:0] fo_r, fo_nxt;
  logic [FLAG_W-1:0] fw_r, fw_nxt;
  logic [DATA_W-1:0] pcn_r, pcn_nxt;
  logic              pcw_r, pcw_nxt;
  logic [DATA_W-1:0] st_r, st_nxt;

  assign s3_rdy    = !s3_vld_r || out_tready;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  // stage 1: operand prep and condition
  logic [DATA_W-1:0] ext_imm, raw;

  always_comb begin
    ext_imm      = {{(DATA_W-IMM_W){in_imm[IMM_W-1]}}, in_imm};
    raw          = in_use_imm ? ext_imm : in_src;
    s1_nxt.op    = in_op;
    s1_nxt.a     = in_sub ? ~raw : raw;
    s1_nxt.op1   = DATA_W'((in_sub ? ~raw : raw) + DATA_W'(in_sub));
    s1_nxt.op2   = in_move ? '0 : in_dst;
    s1_nxt.pc    = in_pc;
    s1_nxt.sub   = in_sub;
    s1_nxt.cin   = in_use_cin & in_flags[FL_C];
    s1_nxt.taken = cond_taken(in_cc, in_flags);
    s1_nxt.rsh   = in_rsh;
  end

  // stage 2: compute units
  logic [DATA_W:0]   sum17;
  logic [DATA_W-1:0] op1_lo;
  logic [DATA_W-1:0] shift_out;
  shift_ctl_t        sh_ctl;

  always_comb begin
    sh_ctl.imm_mode = (s1_r.op == OP_LSHI) || (s1_r.op == OP_ASHI);
    sh_ctl.rsh      = s1_r.rsh;
    sh_ctl.arith    = (s1_r.op == OP_ASH) || (s1_r.op == OP_ASHI);
  end

  reab_shift u_shift (
    .amt    (s1_r.op1),
    .value  (s1_r.op2),
    .ctl    (sh_ctl),
    .result (shift_out)
  );

  always_comb begin
    op1_lo = s1_r.op1 & LOW_BYTE_MASK;
    sum17  = {1'b0, s1_r.a} + {1'b0, s1_r.op2} + (DATA_W+1)'(s1_r.sub)
           + (DATA_W+1)'(s1_r.cin);
    s2_nxt.op        = s1_r.op;
    s2_nxt.sum       = sum17[DATA_W-1:0];
    s2_nxt.carry     = sum17[DATA_W];
    s2_nxt.ovf       = ~(s1_r.a[DATA_W-1] ^ s1_r.op2[DATA_W-1])
                     & (s1_r.a[DATA_W-1] ^ sum17[DATA_W-1]);
    s2_nxt.prod      = DATA_W'(s1_r.op1 * s1_r.op2);
    s2_nxt.shift_res = shift_out;
    s2_nxt.op2       = s1_r.op2;
    if (s1_r.op == OP_MOVI) begin
      s2_nxt.mov_res = DATA_W'(op1_lo + s1_r.op2 + DATA_W'(s1_r.cin));
    end else begin
      s2_nxt.mov_res = DATA_W'(s1_r.op1 + s1_r.op2 + DATA_W'(s1_r.cin));
    end
    case (s1_r.op)
      OP_AND0, OP_AND1: s2_nxt.misc_res = s1_r.op1 & s1_r.op2;
      OP_OR, OP_NOP:    s2_nxt.misc_res = s1_r.op1 | s1_r.op2;
      OP_ORI:           s2_nxt.misc_res = op1_lo | s1_r.op2;
      OP_XOR:           s2_nxt.misc_res = s1_r.op1 ^ s1_r.op2;
      OP_XORI:          s2_nxt.misc_res = op1_lo ^ s1_r.op2;
      OP_LUI:           s2_nxt.misc_res = {s1_r.op1[7:0], 8'h00};
      OP_LOAD, OP_STORE: s2_nxt.misc_res = s1_r.op1;
      OP_JAL:           s2_nxt.misc_res = DATA_W'(s1_r.pc + 1'b1);
      default:          s2_nxt.misc_res = '0;
    endcase
    case (s1_r.op)
      OP_BRANCH: begin
        s2_nxt.pc_wr  = s1_r.taken;
        s2_nxt.pc_tgt = s1_r.taken ? DATA_W'(s1_r.pc + s1_r.op1) : '0;
      end
      OP_JUMP: begin
        s2_nxt.pc_wr  = s1_r.taken;
        s2_nxt.pc_tgt = s1_r.taken ? s1_r.op1 : '0;
      end
      OP_JAL: begin
        s2_nxt.pc_wr  = 1'b1;
        s2_nxt.pc_tgt = s1_r.op2;
      end
      default: begin
        s2_nxt.pc_wr  = 1'b0;
        s2_nxt.pc_tgt = '0;
      end
    endcase
  end

  // stage 3: result select and flags
  logic [FLAG_W-1:0] fo_raw;

  always_comb begin
    res_nxt = '0;
    fo_raw  = '0;
    fw_nxt  = '0;
    case (s2_r.op) inside
      [OP_ADD0:OP_ADD1], [OP_ADD4:OP_ADD9]: begin
        res_nxt      = s2_r.sum;
        fo_raw[FL_F] = s2_r.ovf;
        fw_nxt[FL_F] = 1'b1;
        fw_nxt[FL_Z] = 1'b1;
      end
      [OP_ADDU0:OP_ADDU1]: begin
        res_nxt      = s2_r.sum;
        fo_raw[FL_C] = s2_r.carry;
        fw_nxt[FL_C] = 1'b1;
        fw_nxt[FL_F] = 1'b1;
      end
      [OP_MUL0:OP_MUL1]: res_nxt = s2_r.prod;
      [OP_CMP0:OP_CMP1]: begin
        res_nxt      = s2_r.sum;
        fo_raw[FL_Z] = (s2_r.sum == '0);
        fo_raw[FL_N] = s2_r.sum[DATA_W-1];
        fw_nxt[FL_Z] = 1'b1;
        fw_nxt[FL_N] = 1'b1;
      end
      [OP_MOV:OP_MOVI]:  res_nxt = s2_r.mov_res;
      [OP_LSH:OP_ASHI]:  res_nxt = s2_r.shift_res;
      default:           res_nxt = s2_r.misc_res;
    endcase
    fo_nxt  = fo_raw & fw_nxt;
    pcn_nxt = s2_r.pc_tgt;
    pcw_nxt = s2_r.pc_wr;
    st_nxt  = s2_r.op2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_tvalid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) s1_r <= s1_nxt;
    if (s2_rdy) s2_r <= s2_nxt;
    if (s3_rdy) begin
      res_r <= res_nxt;
      fo_r  <= fo_nxt;
      fw_r  <= fw_nxt;
      pcn_r <= pcn_nxt;
      pcw_r <= pcw_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata  = {7'd0, st_r, pcw_r, pcn_r, fw_r, fo_r, res_r};

endmodule

/* design/reab_shift.sv */
// ----------------------------------------------------------------------------
// reab_shift
// barrel shifter for register and immediate shifts, logical and arithmetic
// ----------------------------------------------------------------------------
module reab_shift
  import reab_pkg::*;
(
  input  logic [DATA_W-1:0] amt,
  input  logic [DATA_W-1:0] value,
  input  shift_ctl_t        ctl,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0]  mag;
  logic               right;
  logic               big;
  logic [SHAMT_W-1:0] n;
  logic               fill_bit;
  logic [DATA_W:0]    ext_val;
  logic [DATA_W:0]    shr_val;

  always_comb begin
    mag      = DATA_W'(~amt + 1'b1);
    fill_bit = ctl.arith & value[DATA_W-1];
    if (ctl.imm_mode) begin
      right = ctl.rsh;
      big   = 1'b0;
      n     = amt[SHAMT_W-1:0];
    end else begin
      right = amt[DATA_W-1];
      big   = right ? |mag[DATA_W-1:SHAMT_W] : |amt[DATA_W-1:SHAMT_W];
      n     = right ? mag[SHAMT_W-1:0] : amt[SHAMT_W-1:0];
    end
    ext_val = {fill_bit, value};
    shr_val = $unsigned($signed(ext_val) >>> n);
    if (big) begin
      result = right ? {DATA_W{fill_bit}} : '0;
    end else if (right) begin
      result = shr_val[DATA_W-1:0];
    end else begin
      result = value << n;
    end
  end

endmodule

/* test/risc_execute_alu_branch_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_execute_alu_branch_check
// watches both stream channels of the execute stage, works out the expected
// result of every accepted instruction and compares each result transfer
// against the oldest outstanding expectation
// ----------------------------------------------------------------------------
module risc_execute_alu_branch_check
  import reab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // op, immediate, source_value, dest_value, pc_value, cond_code, flags_in,
  // use_immediate, subtract, move_op, use_carry_in, shift_right_imm, zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // alu_result, flags_out, flags_write, pc_next, pc_write, store_data, zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     in_flight
);

  typedef struct packed {
    logic [4:0]        pad;
    logic              shift_right_imm;
    logic              use_carry_in;
    logic              move_op;
    logic              subtract;
    logic              use_immediate;
    logic [FLAG_W-1:0] flags_in;
    logic [CC_W-1:0]   cond_code;
    logic [DATA_W-1:0] pc_value;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] source_value;
    logic [IMM_W-1:0]  immediate;
    logic [OP_W-1:0]   op;
  } instr_t;

  typedef struct packed {
    logic [6:0]        pad;
    logic [DATA_W-1:0] store_data;
    logic              pc_write;
    logic [DATA_W-1:0] pc_next;
    logic [FLAG_W-1:0] flags_write;
    logic [FLAG_W-1:0] flags_out;
    logic [DATA_W-1:0] alu_result;
  } exec_result_t;

  localparam int REPORT_LIMIT = 10;

  exec_result_t expected_q[$];
  int           reported;

  function automatic logic [DATA_W-1:0] shift_up(logic [DATA_W-1:0] v, logic [16:0] n);
    if (n >= 17'd16) return '0;
    return v << n[3:0];
  endfunction

  function automatic logic [DATA_W-1:0] shift_down(logic [DATA_W-1:0] v, logic [16:0] n,
                                                   logic arith);
    logic [DATA_W-1:0] fill;
    fill = (arith && v[DATA_W-1]) ? '1 : '0;
    if (n >= 17'd16) return fill;
    if (arith) return DATA_W'($signed(v) >>> n[3:0]);
    return v >> n[3:0];
  endfunction

  // signed register amount, negative means right by the magnitude
  function automatic logic [DATA_W-1:0] shift_by_reg(logic [DATA_W-1:0] amt,
                                                     logic [DATA_W-1:0] v, logic arith);
    if (amt[DATA_W-1]) return shift_down(v, 17'h10000 - {1'b0, amt}, arith);
    return shift_up(v, {1'b0, amt});
  endfunction

  function automatic logic [DATA_W-1:0] shift_by_imm(logic [DATA_W-1:0] amt,
                                                     logic [DATA_W-1:0] v, logic right,
                                                     logic arith);
    if (right) return shift_down(v, {13'd0, amt[3:0]}, arith);
    return shift_up(v, {13'd0, amt[3:0]});
  endfunction

  function automatic logic branch_taken(logic [CC_W-1:0] cc, logic [FLAG_W-1:0] fl);
    case (cc)
      CC_EQ:   return fl[FL_Z];
      CC_NE:   return !fl[FL_Z];
      CC_CS:   return fl[FL_C];
      CC_CC:   return !fl[FL_C];
      CC_N:    return fl[FL_N];
      CC_NN:   return !fl[FL_N];
      CC_FS:   return fl[FL_F];
      CC_FC:   return !fl[FL_F];
      CC_LE:   return fl[FL_Z] || fl[FL_N];
      CC_GT:   return !fl[FL_N] && !fl[FL_Z];
      CC_AL:   return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic exec_result_t execute_instr(instr_t it);
    exec_result_t      r;
    logic [DATA_W-1:0] ext, raw, a, op1, op2, sum, ovf_vec;
    logic [16:0]       sum17;
    logic              cin, ovf;
    logic [FLAG_W-1:0] fo, fw;
    logic              is_add;
    r   = '0;
    fo  = '0;
    fw  = '0;
    cin = it.use_carry_in & it.flags_in[FL_C];
    ext = {{(DATA_W-IMM_W){it.immediate[IMM_W-1]}}, it.immediate};
    raw = it.use_immediate ? ext : it.source_value;
    a   = it.subtract ? ~raw : raw;
    op1 = a + DATA_W'(it.subtract);
    op2 = it.move_op ? '0 : it.dest_value;
    sum17 = {1'b0, a} + {1'b0, op2} + 17'(it.subtract) + 17'(cin);
    sum   = sum17[DATA_W-1:0];
    ovf_vec = ~(a ^ op2) & (a ^ sum);
    ovf   = ovf_vec[DATA_W-1];
    is_add = (it.op == OP_ADD0) || (it.op == OP_ADD1) ||
             (it.op >= OP_ADD4 && it.op <= OP_ADD9);
    if (is_add) begin
      r.alu_result = sum;
      fo[FL_F] = ovf;
      fw[FL_F] = 1'b1;
      fw[FL_Z] = 1'b1;
    end else begin
      case (it.op)
        OP_ADDU0, OP_ADDU1: begin
          r.alu_result = sum;
          fo[FL_C] = sum17[16];
          fw[FL_C] = 1'b1;
          fw[FL_F] = 1'b1;
        end
        OP_MUL0, OP_MUL1: r.alu_result = op1 * op2;
        OP_CMP0, OP_CMP1: begin
          r.alu_result = sum;
          fo[FL_Z] = (sum == '0);
          fo[FL_N] = sum[DATA_W-1];
          fw[FL_Z] = 1'b1;
          fw[FL_N] = 1'b1;
        end
        OP_AND0, OP_AND1: r.alu_result = op1 & op2;
        OP_OR, OP_NOP:    r.alu_result = op1 | op2;
        OP_ORI:           r.alu_result = (op1 & LOW_BYTE_MASK) | op2;
        OP_XOR:           r.alu_result = op1 ^ op2;
        OP_XORI:          r.alu_result = (op1 & LOW_BYTE_MASK) ^ op2;
        OP_MOV:           r.alu_result = op1 + op2 + DATA_W'(cin);
        OP_MOVI:          r.alu_result = (op1 & LOW_BYTE_MASK) + op2 + DATA_W'(cin);
        OP_LSH:           r.alu_result = shift_by_reg(op1, op2, 1'b0);
        OP_LSHI:          r.alu_result = shift_by_imm(op1, op2, it.shift_right_imm, 1'b0);
        OP_ASH:           r.alu_result = shift_by_reg(op1, op2, 1'b1);
        OP_ASHI:          r.alu_result = shift_by_imm(op1, op2, it.shift_right_imm, 1'b1);
        OP_LUI:           r.alu_result = {op1[7:0], 8'h00};
        OP_LOAD, OP_STORE: r.alu_result = op1;
        OP_BRANCH: begin
          if (branch_taken(it.cond_code, it.flags_in)) begin
            r.pc_next  = it.pc_value + op1;
            r.pc_write = 1'b1;
          end
        end
        OP_JUMP: begin
          if (branch_taken(it.cond_code, it.flags_in)) begin
            r.pc_next  = op1;
            r.pc_write = 1'b1;
          end
        end
        OP_JAL: begin
          r.alu_result = it.pc_value + 16'd1;
          r.pc_next    = op2;
          r.pc_write   = 1'b1;
        end
        default: ;
      endcase
    end
    r.flags_out   = fo & fw;
    r.flags_write = fw;
    r.store_data  = op2;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    in_flight  = 0;
    reported   = 0;
  end

  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_q.push_back(execute_instr(instr_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = exec_result_t'(out_tdata);
        if (expected_q.size() == 0) begin
          fail_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result transfer: %h", out_tdata);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("mismatch at %0t: exp res=%h fo=%h fw=%h pcn=%h pcw=%b sd=%h pad=%h",
                       $realtime, want.alu_result, want.flags_out, want.flags_write,
                       want.pc_next, want.pc_write, want.store_data, want.pad);
              $display("                  got res=%h fo=%h fw=%h pcn=%h pcw=%b sd=%h pad=%h",
                       got.alu_result, got.flags_out, got.flags_write,
                       got.pc_next, got.pc_write, got.store_data, got.pad);
            end
          end
        end
      end
      in_flight = expected_q.size();
    end
  end

endmodule

/* test/risc_execute_alu_branch_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_execute_alu_branch_test
// drives instructions into the execute stage, first a directed set of corner
// cases and then random instructions over several idle and stall phases;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module risc_execute_alu_branch_test;
  import reab_pkg::*;

  typedef struct packed {
    logic [4:0]        pad;
    logic              shift_right_imm;
    logic              use_carry_in;
    logic              move_op;
    logic              subtract;
    logic              use_immediate;
    logic [FLAG_W-1:0] flags_in;
    logic [CC_W-1:0]   cond_code;
    logic [DATA_W-1:0] pc_value;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] source_value;
    logic [IMM_W-1:0]  immediate;
    logic [OP_W-1:0]   op;
  } instr_t;

  localparam logic [4:0] CTL_NONE = 5'b00000;
  localparam logic [4:0] CTL_IMM  = 5'b00001;
  localparam logic [4:0] CTL_SUB  = 5'b00010;
  localparam logic [4:0] CTL_MOV  = 5'b00100;
  localparam logic [4:0] CTL_CIN  = 5'b01000;
  localparam logic [4:0] CTL_RSH  = 5'b10000;

  localparam logic [OP_W-1:0] OP_TOP = {OP_W{1'b1}};
  localparam logic [CC_W-1:0] CC_UNLISTED = 4'd4;

  localparam int PHASE_ITEMS = 250;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     in_flight;
  int                     send_idle;
  int                     recv_stall;

  risc_execute_alu_branch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  risc_execute_alu_branch_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic instr_t make_instr(logic [OP_W-1:0] op, logic [IMM_W-1:0] imm,
                                        logic [DATA_W-1:0] src, logic [DATA_W-1:0] dst,
                                        logic [DATA_W-1:0] pc, logic [CC_W-1:0] cc,
                                        logic [FLAG_W-1:0] fl, logic [4:0] ctl);
    instr_t it;
    it = '0;
    it.op              = op;
    it.immediate       = imm;
    it.source_value    = src;
    it.dest_value      = dst;
    it.pc_value        = pc;
    it.cond_code       = cc;
    it.flags_in        = fl;
    it.use_immediate   = ctl[0];
    it.subtract        = ctl[1];
    it.move_op         = ctl[2];
    it.use_carry_in    = ctl[3];
    it.shift_right_imm = ctl[4];
    return it;
  endfunction

  // corner values are picked often so shifts and carries hit their edges
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return DATA_W'($urandom_range(20));
      5: return 16'hFFFF - DATA_W'($urandom_range(20));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic instr_t random_instr();
    logic [OP_W-1:0] op;
    op = ($urandom_range(15) == 0) ? OP_W'($urandom_range(OP_TOP, OP_NOP + 1))
                                   : OP_W'($urandom_range(OP_NOP));
    return make_instr(op, IMM_W'($urandom), pick_word(), pick_word(), pick_word(),
                      CC_W'($urandom), FLAG_W'($urandom), 5'($urandom));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_instr(input instr_t it);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (PHASE_ITEMS) send_instr(random_instr());
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    send_idle  = 0;
    recv_stall = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases
    send_instr(make_instr(OP_ADD0, 8'h00, 16'h7FFF, 16'h0001, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_ADD1, 8'h00, 16'h0000, 16'h0000, 16'h0000, CC_EQ, 4'hF, CTL_SUB));
    send_instr(make_instr(OP_ADDU0, 8'h00, 16'hFFFF, 16'h0001, 16'h0000, CC_EQ, 4'h1, CTL_CIN));
    send_instr(make_instr(OP_ADD9, 8'h80, 16'h1234, 16'h8000, 16'h0000, CC_EQ, 4'h0,
                          CTL_IMM | CTL_SUB));
    send_instr(make_instr(OP_MUL0, 8'h00, 16'hFFFF, 16'hFFFF, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_CMP0, 8'h00, 16'h1234, 16'h1234, 16'h0000, CC_EQ, 4'h0, CTL_SUB));
    send_instr(make_instr(OP_CMP1, 8'h00, 16'h0000, 16'h8000, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_AND0, 8'hFF, 16'h0000, 16'hAAAA, 16'h0000, CC_EQ, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_OR, 8'h00, 16'h5555, 16'hAAAA, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_ORI, 8'h7F, 16'h0000, 16'h0F00, 16'h0000, CC_EQ, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_XOR, 8'h00, 16'hFFFF, 16'hFFFF, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_XORI, 8'h80, 16'h0000, 16'hFFFF, 16'h0000, CC_EQ, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_MOV, 8'h00, 16'h8001, 16'hFFFF, 16'h0000, CC_EQ, 4'h1,
                          CTL_MOV | CTL_CIN));
    send_instr(make_instr(OP_MOVI, 8'hFF, 16'h0000, 16'h1234, 16'h0000, CC_EQ, 4'h1,
                          CTL_IMM | CTL_MOV | CTL_CIN));
    send_instr(make_instr(OP_LSH, 8'h00, 16'hFFFC, 16'h8001, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_LSH, 8'h00, 16'h0010, 16'hFFFF, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_ASH, 8'h00, 16'h8000, 16'h8000, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_ASHI, 8'h0F, 16'h0000, 16'h8000, 16'h0000, CC_EQ, 4'h0,
                          CTL_IMM | CTL_RSH));
    send_instr(make_instr(OP_LSHI, 8'h00, 16'h0003, 16'h00FF, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_LUI, 8'hAB, 16'h0000, 16'h0000, 16'h0000, CC_EQ, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_LOAD, 8'h00, 16'h1000, 16'h0000, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_STORE, 8'h00, 16'hFFFF, 16'hBEEF, 16'h0000, CC_EQ, 4'h0,
                          CTL_NONE));
    send_instr(make_instr(OP_BRANCH, 8'h80, 16'h0000, 16'h0000, 16'hFFFF, CC_AL, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_BRANCH, 8'h05, 16'h0000, 16'h0000, 16'h0010, CC_GT, 4'h0, CTL_IMM));
    send_instr(make_instr(OP_JUMP, 8'h00, 16'h4321, 16'h0000, 16'h0000, CC_UNLISTED, 4'hF,
                          CTL_NONE));
    send_instr(make_instr(OP_JAL, 8'h00, 16'h0000, 16'h4000, 16'hFFFF, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_NOP, 8'h00, 16'h00F0, 16'h0F00, 16'h0000, CC_EQ, 4'h0, CTL_NONE));
    send_instr(make_instr(OP_TOP, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, CC_AL, 4'hF, 5'h1F));
    drain();

    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(7, 7);
    run_phase(0, 0);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/reab_pkg.sv
design/reab_shift.sv
design/risc_execute_alu_branch.sv
test/risc_execute_alu_branch_check.sv
test/risc_execute_alu_branch_test.sv
